// ===== hw/rtl/bfx_pkg.sv =====
// Shared types, opcodes, error codes and the source character decoder.
`default_nettype none

package bfx_pkg;

  // Stored 3-bit instruction codes.
  typedef enum logic [2:0] {
    OP_RIGHT = 3'd0,
    OP_LEFT  = 3'd1,
    OP_INC   = 3'd2,
    OP_DEC   = 3'd3,
    OP_OUT   = 3'd4,
    OP_IN    = 3'd5,
    OP_OPEN  = 3'd6,
    OP_CLOSE = 3'd7
  } op_t;

  // Latched error codes.
  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_UNBAL = 3'd1,
    ERR_OVER  = 3'd2,
    ERR_UNDER = 3'd3,
    ERR_FULL  = 3'd4
  } err_t;

  // Source characters of the eight commands.
  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_INC   = 8'h2B;
  localparam logic [7:0] CH_DEC   = 8'h2D;
  localparam logic [7:0] CH_OUT   = 8'h2E;
  localparam logic [7:0] CH_IN    = 8'h2C;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;

  typedef struct packed {
    logic ok;
    op_t  op;
  } dec_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic item_load;
    logic do_load;
    logic set_unbal;
    logic rd_issue;
    logic do_op;
    logic scan_miss;
    logic scan_rd;
    logic scan_ck;
    logic resp_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic err_set;
    logic is_load;
    logic bal_nz;
    logic at_end;
    logic scan_start;
    logic scan_end;
    logic scan_found;
  } dp_status_t;

  function automatic dec_t decode_char(input logic [7:0] c);
    dec_t d;
    d.ok = 1'b1;
    d.op = OP_RIGHT;
    unique case (c)
      CH_RIGHT: d.op = OP_RIGHT;
      CH_LEFT:  d.op = OP_LEFT;
      CH_INC:   d.op = OP_INC;
      CH_DEC:   d.op = OP_DEC;
      CH_OUT:   d.op = OP_OUT;
      CH_IN:    d.op = OP_IN;
      CH_OPEN:  d.op = OP_OPEN;
      CH_CLOSE: d.op = OP_CLOSE;
      default:  d.ok = 1'b0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bfx_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module bfx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bfx_ctrl.sv =====
// Controller state machine that sequences clearing, loads, execution and scans.
`default_nettype none

module bfx_ctrl import bfx_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_stall,
  output logic            result_valid,
  input  wire logic       result_stall,
  output ctrl_cmd_t       ctl,
  input  wire dp_status_t sts
);

  typedef enum logic [6:0] {
    S_CLEAR    = 7'b0000001,
    S_IDLE     = 7'b0000010,
    S_DISPATCH = 7'b0000100,
    S_OP       = 7'b0001000,
    S_SCAN_RD  = 7'b0010000,
    S_SCAN_CK  = 7'b0100000,
    S_RESP     = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   res_valid;
  logic   res_free;

  assign res_free     = !res_valid || !result_stall;
  assign item_stall   = (state != S_IDLE);
  assign result_valid = res_valid;

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (item_valid) begin
          ctl.item_load = 1'b1;
          state_next    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.err_set) begin
          state_next = S_RESP;
        end else if (sts.is_load) begin
          ctl.do_load = 1'b1;
          state_next  = S_RESP;
        end else if (sts.bal_nz) begin
          ctl.set_unbal = 1'b1;
          state_next    = S_RESP;
        end else if (sts.at_end) begin
          state_next = S_RESP;
        end else begin
          ctl.rd_issue = 1'b1;
          state_next   = S_OP;
        end
      end
      S_OP: begin
        ctl.do_op  = 1'b1;
        state_next = sts.scan_start ? S_SCAN_RD : S_RESP;
      end
      S_SCAN_RD: begin
        if (sts.scan_end) begin
          ctl.scan_miss = 1'b1;
          state_next    = S_RESP;
        end else begin
          ctl.scan_rd = 1'b1;
          state_next  = S_SCAN_CK;
        end
      end
      S_SCAN_CK: begin
        ctl.scan_ck = 1'b1;
        state_next  = sts.scan_found ? S_RESP : S_SCAN_RD;
      end
      S_RESP: begin
        if (res_free) begin
          ctl.resp_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.resp_load) begin
        res_valid <= 1'b1;
      end else if (!result_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bfx_dpath.sv =====
// Datapath: program, cell and return stack memories, machine registers, result register.
`default_nettype none

module bfx_dpath import bfx_pkg::*; #(
  parameter int PROG_DEPTH  = 4096,
  parameter int CELL_COUNT  = 32768,
  parameter int STACK_DEPTH = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire ctrl_cmd_t  ctl,
  output dp_status_t      sts,
  input  wire logic       cmd,
  input  wire logic [7:0] src_char,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  output logic [7:0]      out_data,
  output logic            in_used,
  output logic            halted,
  output logic [2:0]      error_code
);

  localparam int AW  = $clog2(PROG_DEPTH);
  localparam int LW  = $clog2(PROG_DEPTH + 1);
  localparam int DW  = $clog2(CELL_COUNT);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SCW = $clog2(STACK_DEPTH + 1);

  // Captured item.
  logic          item_cmd;
  logic [7:0]    item_char;
  logic [7:0]    item_byte;

  // Machine state.
  logic [LW-1:0] prog_len;
  logic [LW-1:0] pc;
  logic [DW-1:0] dp;
  logic [SCW-1:0] stk_cnt;
  logic [LW-1:0] balance;
  err_t          err;
  logic [DW-1:0] clr_addr;

  // Forward scan.
  logic [LW-1:0] scan_idx;
  logic [LW-1:0] scan_depth;

  // Pending result fields.
  logic          pend_ov;
  logic [7:0]    pend_ob;
  logic          pend_iu;

  // Memory ports.
  logic          prog_we;
  logic [2:0]    prog_rd;
  logic          cell_we;
  logic [DW-1:0] cell_addr;
  logic [7:0]    cell_wd;
  logic [7:0]    cell_rd;
  logic          stk_we;
  logic [SCW-1:0] stk_top;
  logic [AW-1:0] stk_rd;

  dec_t          dec;
  op_t           op;
  logic          stk_full;
  logic          cell_zero;

  assign dec       = decode_char(item_char);
  assign op        = op_t'(prog_rd);
  assign stk_full  = (stk_cnt == SCW'(STACK_DEPTH));
  assign cell_zero = (cell_rd == 8'd0);
  assign stk_top   = stk_cnt - SCW'(1);

  assign sts.clr_last   = (clr_addr == DW'(CELL_COUNT - 1));
  assign sts.err_set    = (err != ERR_NONE);
  assign sts.is_load    = !item_cmd;
  assign sts.bal_nz     = (balance != '0);
  assign sts.at_end     = (pc >= prog_len);
  assign sts.scan_start = (op == OP_OPEN) && cell_zero;
  assign sts.scan_end   = (scan_idx >= prog_len);
  assign sts.scan_found = (op == OP_CLOSE) && (scan_depth == '0);

  assign prog_we = ctl.do_load && dec.ok && (prog_len != LW'(PROG_DEPTH));

  bfx_ram #(.WIDTH(3), .DEPTH(PROG_DEPTH)) u_prog_ram (
    .clk     (clk),
    .wr_en   (prog_we),
    .wr_addr (prog_len[AW-1:0]),
    .wr_data (dec.op),
    .rd_en   (ctl.rd_issue || ctl.scan_rd),
    .rd_addr (ctl.scan_rd ? scan_idx[AW-1:0] : pc[AW-1:0]),
    .rd_data (prog_rd)
  );

  always_comb begin
    cell_we   = 1'b0;
    cell_addr = dp;
    cell_wd   = cell_rd;
    if (ctl.clr_step) begin
      cell_we   = 1'b1;
      cell_addr = clr_addr;
      cell_wd   = 8'd0;
    end else if (ctl.do_op) begin
      case (op)
        OP_INC: begin
          cell_we = 1'b1;
          cell_wd = cell_rd + 8'd1;
        end
        OP_DEC: begin
          cell_we = 1'b1;
          cell_wd = cell_rd - 8'd1;
        end
        OP_IN: begin
          cell_we = 1'b1;
          cell_wd = item_byte;
        end
        default: cell_we = 1'b0;
      endcase
    end
  end

  bfx_ram #(.WIDTH(8), .DEPTH(CELL_COUNT)) u_cell_ram (
    .clk     (clk),
    .wr_en   (cell_we),
    .wr_addr (cell_addr),
    .wr_data (cell_wd),
    .rd_en   (ctl.rd_issue),
    .rd_addr (dp),
    .rd_data (cell_rd)
  );

  assign stk_we = ctl.do_op && (op == OP_OPEN) && !cell_zero && !stk_full;

  bfx_ram #(.WIDTH(AW), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (stk_cnt[SAW-1:0]),
    .wr_data (pc[AW-1:0]),
    .rd_en   (ctl.rd_issue),
    .rd_addr (stk_top[SAW-1:0]),
    .rd_data (stk_rd)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      prog_len <= '0;
      pc       <= '0;
      dp       <= '0;
      stk_cnt  <= '0;
      balance  <= '0;
      err      <= ERR_NONE;
      clr_addr <= '0;
    end else begin
      if (ctl.clr_step) begin
        clr_addr <= clr_addr + DW'(1);
      end
      if (ctl.set_unbal) begin
        err <= ERR_UNBAL;
      end
      if (ctl.do_load && dec.ok) begin
        if (prog_len == LW'(PROG_DEPTH)) begin
          err <= ERR_FULL;
        end else begin
          prog_len <= prog_len + LW'(1);
          if (dec.op == OP_OPEN) begin
            balance <= balance + LW'(1);
          end else if (dec.op == OP_CLOSE) begin
            if (balance == '0) begin
              err <= ERR_UNBAL;
            end else begin
              balance <= balance - LW'(1);
            end
          end
        end
      end
      if (ctl.do_op) begin
        unique case (op)
          OP_RIGHT: begin
            dp <= (dp == DW'(CELL_COUNT - 1)) ? '0 : dp + DW'(1);
            pc <= pc + LW'(1);
          end
          OP_LEFT: begin
            dp <= (dp == '0) ? DW'(CELL_COUNT - 1) : dp - DW'(1);
            pc <= pc + LW'(1);
          end
          OP_INC, OP_DEC, OP_OUT, OP_IN: pc <= pc + LW'(1);
          OP_OPEN: begin
            if (!cell_zero) begin
              if (stk_full) begin
                err <= ERR_OVER;
              end else begin
                stk_cnt <= stk_cnt + SCW'(1);
                pc      <= pc + LW'(1);
              end
            end
          end
          OP_CLOSE: begin
            if (stk_cnt == '0) begin
              err <= ERR_UNDER;
            end else if (!cell_zero) begin
              pc <= LW'(stk_rd) + LW'(1);
            end else begin
              stk_cnt <= stk_cnt - SCW'(1);
              pc      <= pc + LW'(1);
            end
          end
        endcase
      end
      if (ctl.scan_miss) begin
        pc <= prog_len;
      end
      if (ctl.scan_ck && sts.scan_found) begin
        pc <= scan_idx + LW'(1);
      end
    end
  end

  // Item capture, scan registers, pending and delivered result fields.
  always_ff @(posedge clk) begin
    if (ctl.item_load) begin
      item_cmd  <= cmd;
      item_char <= src_char;
      item_byte <= in_byte;
      pend_ov   <= 1'b0;
      pend_ob   <= 8'd0;
      pend_iu   <= 1'b0;
    end
    if (ctl.do_op) begin
      if (op == OP_OUT) begin
        pend_ov <= 1'b1;
        pend_ob <= cell_rd;
      end
      if (op == OP_IN) begin
        pend_iu <= 1'b1;
      end
      scan_idx   <= pc + LW'(1);
      scan_depth <= '0;
    end
    if (ctl.scan_ck) begin
      if (op == OP_OPEN) begin
        scan_depth <= scan_depth + LW'(1);
        scan_idx   <= scan_idx + LW'(1);
      end else if (op == OP_CLOSE) begin
        if (scan_depth != '0) begin
          scan_depth <= scan_depth - LW'(1);
          scan_idx   <= scan_idx + LW'(1);
        end
      end else begin
        scan_idx <= scan_idx + LW'(1);
      end
    end
    if (ctl.resp_load) begin
      out_valid  <= pend_ov;
      out_data   <= pend_ob;
      in_used    <= pend_iu;
      halted     <= (pc >= prog_len);
      error_code <= err;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bf_program_executor.sv =====
// Top level: program executor built from a controller and a datapath.
// A load, or an execute that finds an error, open brackets or a halted program, goes from
// dispatch straight to loading its result; no new item is taken before that result is loaded.
// An executed instruction issues its reads at dispatch and runs in the operation state; a forward
// bracket skip reads and checks each scanned instruction in turn, up to the end if no match exists.
// Synchronous active-high reset; a clearing pass then zeroes every cell, taking no item.
`default_nettype none

module bf_program_executor import bfx_pkg::*; #(
  parameter int PROG_DEPTH  = 4096,
  parameter int CELL_COUNT  = 32768,
  parameter int STACK_DEPTH = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // Input item channel.
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire logic       cmd,
  input  wire logic [7:0] src_char,
  input  wire logic [7:0] in_byte,
  // Result channel.
  output logic            result_valid,
  input  wire logic       result_stall,
  output logic            out_valid,
  output logic [7:0]      out_data,
  output logic            in_used,
  output logic            halted,
  output logic [2:0]      error_code
);

  // The controller takes one item at a time: it captures the item, dispatches
  // a load or an execute, waits for the registered memory reads, runs the
  // optional forward bracket scan, and finally moves the result into the
  // output register. The output register holds a finished result until its
  // transfer, so the controller only waits at the end when the previous result
  // has not yet been taken.
  ctrl_cmd_t  ctl;
  dp_status_t sts;

  bfx_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .ctl          (ctl),
    .sts          (sts)
  );

  // The datapath holds the program store, the cells and the return stack as
  // RAMs, plus the program counter, data pointer, stack count, bracket balance
  // and the sticky error register.
  bfx_dpath #(
    .PROG_DEPTH  (PROG_DEPTH),
    .CELL_COUNT  (CELL_COUNT),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .cmd        (cmd),
    .src_char   (src_char),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .in_used    (in_used),
    .halted     (halted),
    .error_code (error_code)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/bfx_checker.sv =====
// Port-level assertions for the program executor and their bind statement.
`default_nettype none

module bfx_checker import bfx_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       item_valid,
  input wire logic       item_stall,
  input wire logic       result_valid,
  input wire logic       result_stall,
  input wire logic       out_valid,
  input wire logic [7:0] out_data,
  input wire logic [2:0] error_code
);

  // A stalled result stays offered.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result withdrawn while stalled");

  // Items are processed one at a time: a transfer closes the input side.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("input accepted during item processing");

  // Errors are sticky until reset.
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    result_valid && (error_code != ERR_NONE) |=> $stable(error_code))
    else $error("latched error code changed");

  // Only an output instruction carries a cell value.
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !out_valid |-> (out_data == 8'd0))
    else $error("out_data nonzero without output");

endmodule

bind bf_program_executor bfx_checker u_bfx_checker (.*);

`default_nettype wire
